// ===== rtl/tcg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_pkg
// Shared widths, constants, register codes and stage payload types of the
// timed crossfade gain pipeline.
// ----------------------------------------------------------------------------
package tcg_pkg;

  localparam int TIME_W    = 64;
  localparam int LEN_W     = 13;
  localparam int IDX_W     = 12;
  localparam int SAMPLE_W  = 24;
  localparam int Q_W       = 24;
  localparam int FRAC_W    = 23;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 64;

  localparam logic [Q_W-1:0]   ONE       = 24'h800000;
  localparam logic [LEN_W-1:0] MAX_BLOCK = 13'd4096;

  // restoring divider for the window ratios, one bit a stage
  localparam int RATIO_STEPS    = 24;
  // lerp quotient: 24 bits, four bits a stage
  localparam int QDIV_STEPS     = 24;
  localparam int QDIV_PER_STAGE = 4;
  localparam int QDIV_STAGES    = QDIV_STEPS / QDIV_PER_STAGE;
  // log2 by repeated squaring, one squaring a stage
  localparam int LOG_STEPS      = 24;

  typedef enum logic [1:0] {
    REG_FADE_START = 2'd0,
    REG_FADE_END   = 2'd1,
    REG_RAMP_DOWN  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic                       pass;
    logic                       rd;
    logic                       zero_d;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           f;
    logic [IDX_W-1:0]           a;
    logic [IDX_W-1:0]           b;
    logic [TIME_W-1:0]          num_s;
    logic [TIME_W-1:0]          num_e;
    logic [TIME_W-1:0]          den;
  } front_t;

  typedef struct packed {
    logic                       pass;
    logic                       rd;
    logic                       zero_d;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           f;
    logic [IDX_W-1:0]           a;
    logic [IDX_W-1:0]           b;
    logic [Q_W-1:0]             rs;
    logic [Q_W-1:0]             re;
  } ratio_t;

  typedef struct packed {
    logic                       pass;
    logic signed [SAMPLE_W-1:0] sample;
    logic [Q_W-1:0]             gain;
  } lerp_t;

  typedef struct packed {
    logic                       pass;
    logic signed [SAMPLE_W-1:0] sample;
    logic [Q_W-1:0]             scale;
  } log_t;

endpackage

// ===== rtl/tcg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_front
// Three stages: block end, window clipping, window offsets and pass decision.
// ----------------------------------------------------------------------------
module tcg_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic [tcg_pkg::TIME_W-1:0]          bs_i,
  input  logic [tcg_pkg::LEN_W-1:0]           len_i,
  input  logic [tcg_pkg::IDX_W-1:0]           f_i,
  input  logic signed [tcg_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [tcg_pkg::TIME_W-1:0]          st_i,
  input  logic [tcg_pkg::TIME_W-1:0]          fend_i,
  input  logic                                rd_i,
  output logic                                vld_o,
  output tcg_pkg::front_t                     data_o
);
  import tcg_pkg::*;

  logic [LEN_W-1:0]  len_c;
  logic [LEN_W-1:0]  lenm1;
  logic [TIME_W:0]   be_sum;
  logic [TIME_W-1:0] be_d;

  logic                       v1_q, v2_q, v3_q;
  logic [TIME_W-1:0]          bs1_q, be1_q, st1_q, en1_q;
  logic [IDX_W-1:0]           f1_q, f2_q;
  logic signed [SAMPLE_W-1:0] s1_q, s2_q;
  logic                       rd1_q, rd2_q, zd1_q, zd2_q;
  logic                       rev1_q, enltbs1_q, stgtbs1_q;
  logic [TIME_W-1:0]          ws2_q, we2_q, bs2_q, st2_q, den2_q;
  logic                       nov2_q;
  front_t                     out_q;

  logic [IDX_W-1:0] a_c, b_c;

  // clamp length and form the saturated block end
  always_comb begin
    if (len_i == '0) begin
      len_c = LEN_W'(1);
    end else if (len_i > MAX_BLOCK) begin
      len_c = MAX_BLOCK;
    end else begin
      len_c = len_i;
    end
    lenm1  = len_c - LEN_W'(1);
    be_sum = {1'b0, bs_i} + {{(TIME_W+1-LEN_W){1'b0}}, lenm1};
    be_d   = be_sum[TIME_W] ? '1 : be_sum[TIME_W-1:0];
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bs1_q     <= bs_i;
      be1_q     <= be_d;
      st1_q     <= st_i;
      en1_q     <= fend_i;
      f1_q      <= f_i;
      s1_q      <= sample_i;
      rd1_q     <= rd_i;
      zd1_q     <= (fend_i == st_i);
      rev1_q    <= (st_i > fend_i);
      enltbs1_q <= (fend_i < bs_i);
      stgtbs1_q <= (st_i > bs_i);
    end
  end

  // stage 2: clip the window to the block
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ws2_q  <= stgtbs1_q ? st1_q : bs1_q;
      we2_q  <= (en1_q < be1_q) ? en1_q : be1_q;
      nov2_q <= rev1_q | enltbs1_q | (st1_q > be1_q);
      bs2_q  <= bs1_q;
      st2_q  <= st1_q;
      den2_q <= en1_q - st1_q;
      f2_q   <= f1_q;
      s2_q   <= s1_q;
      rd2_q  <= rd1_q;
      zd2_q  <= zd1_q;
    end
  end

  // offsets fit in the index width whenever the window overlaps the block
  assign a_c = ws2_q[IDX_W-1:0] - bs2_q[IDX_W-1:0];
  assign b_c = we2_q[IDX_W-1:0] - bs2_q[IDX_W-1:0];

  // stage 3
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.pass   <= nov2_q | (f2_q < a_c) | (f2_q > b_c);
      out_q.rd     <= rd2_q;
      out_q.zero_d <= zd2_q;
      out_q.sample <= s2_q;
      out_q.f      <= f2_q;
      out_q.a      <= a_c;
      out_q.b      <= b_c;
      out_q.num_s  <= ws2_q - st2_q;
      out_q.num_e  <= we2_q - st2_q;
      out_q.den    <= den2_q;
    end
  end

  assign vld_o  = v3_q;
  assign data_o = out_q;

endmodule

// ===== rtl/tcg_ratio.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_ratio
// Two lanes of a pipelined restoring divider: window edge offsets over the
// window duration, Q1.23, rounded half up.
// ----------------------------------------------------------------------------
module tcg_ratio (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  tcg_pkg::front_t data_i,
  output logic            vld_o,
  output tcg_pkg::ratio_t data_o
);
  import tcg_pkg::*;

  typedef struct packed {
    logic                       pass;
    logic                       rd;
    logic                       zero_d;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           f;
    logic [IDX_W-1:0]           a;
    logic [IDX_W-1:0]           b;
  } side_t;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [TIME_W:0] div_step(logic [TIME_W-1:0] r, logic [TIME_W-1:0] den);
    logic [TIME_W:0] t;
    logic [TIME_W:0] d;
    t = {r, 1'b0};
    d = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      return {1'b1, d[TIME_W-1:0]};
    end
    return {1'b0, t[TIME_W-1:0]};
  endfunction

  logic              v_q   [0:RATIO_STEPS];
  side_t             sd_q  [0:RATIO_STEPS];
  logic [TIME_W-1:0] den_q [0:RATIO_STEPS];
  logic [TIME_W-1:0] rs_q  [0:RATIO_STEPS];
  logic [TIME_W-1:0] re_q  [0:RATIO_STEPS];
  logic [Q_W-1:0]    qs_q  [0:RATIO_STEPS];
  logic [Q_W-1:0]    qe_q  [0:RATIO_STEPS];
  logic              ss_q  [0:RATIO_STEPS];
  logic              se_q  [0:RATIO_STEPS];
  logic              vo_q;
  ratio_t            out_q;

  logic [Q_W:0] rnd_s, rnd_e;

  // stage 0: load and flag a full-scale ratio
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[0]  <= '{pass: data_i.pass, rd: data_i.rd, zero_d: data_i.zero_d,
                    sample: data_i.sample, f: data_i.f, a: data_i.a, b: data_i.b};
      den_q[0] <= data_i.den;
      rs_q[0]  <= data_i.num_s;
      re_q[0]  <= data_i.num_e;
      qs_q[0]  <= '0;
      qe_q[0]  <= '0;
      ss_q[0]  <= (data_i.num_s >= data_i.den);
      se_q[0]  <= (data_i.num_e >= data_i.den);
    end
  end

  // one quotient bit per stage in each lane
  for (genvar i = 0; i < RATIO_STEPS; i++) begin : g_step
    logic [TIME_W:0] st_s, st_e;
    assign st_s = div_step(rs_q[i], den_q[i]);
    assign st_e = div_step(re_q[i], den_q[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q[i+1]  <= sd_q[i];
        den_q[i+1] <= den_q[i];
        rs_q[i+1]  <= st_s[TIME_W-1:0];
        re_q[i+1]  <= st_e[TIME_W-1:0];
        qs_q[i+1]  <= {qs_q[i][Q_W-2:0], st_s[TIME_W]};
        qe_q[i+1]  <= {qe_q[i][Q_W-2:0], st_e[TIME_W]};
        ss_q[i+1]  <= ss_q[i];
        se_q[i+1]  <= se_q[i];
      end
    end
  end

  // round half up
  assign rnd_s = {1'b0, qs_q[RATIO_STEPS]} + (Q_W+1)'(1);
  assign rnd_e = {1'b0, qe_q[RATIO_STEPS]} + (Q_W+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[RATIO_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.pass   <= sd_q[RATIO_STEPS].pass;
      out_q.rd     <= sd_q[RATIO_STEPS].rd;
      out_q.zero_d <= sd_q[RATIO_STEPS].zero_d;
      out_q.sample <= sd_q[RATIO_STEPS].sample;
      out_q.f      <= sd_q[RATIO_STEPS].f;
      out_q.a      <= sd_q[RATIO_STEPS].a;
      out_q.b      <= sd_q[RATIO_STEPS].b;
      out_q.rs     <= ss_q[RATIO_STEPS] ? ONE : rnd_s[Q_W:1];
      out_q.re     <= se_q[RATIO_STEPS] ? ONE : rnd_e[Q_W:1];
    end
  end

  assign vld_o  = vo_q;
  assign data_o = out_q;

endmodule

// ===== rtl/tcg_lerp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_lerp
// Edge levels, per-frame interpolation and the pipelined divide by the
// frame count, then the clamped gain.
// ----------------------------------------------------------------------------
module tcg_lerp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  tcg_pkg::ratio_t data_i,
  output logic            vld_o,
  output tcg_pkg::lerp_t  data_o
);
  import tcg_pkg::*;

  localparam int PROD_W = LEN_W + Q_W;
  localparam int PACK_W = LEN_W + 2 * Q_W;

  typedef struct packed {
    logic                       pass;
    logic                       rd;
    logic                       zero_d;
    logic signed [SAMPLE_W-1:0] sample;
    logic [Q_W-1:0]             gs;
    logic                       up;
    logic [LEN_W-1:0]           n;
  } ls_t;

  // several restoring steps on the narrow remainder
  function automatic logic [PACK_W-1:0] div_steps(logic [LEN_W-1:0] rem, logic [Q_W-1:0] lo,
                                                  logic [Q_W-1:0] q, logic [LEN_W-1:0] n);
    logic [LEN_W:0]   t;
    logic [LEN_W-1:0] r;
    logic [Q_W-1:0]   l;
    logic [Q_W-1:0]   qq;
    r  = rem;
    l  = lo;
    qq = q;
    for (int j = 0; j < QDIV_PER_STAGE; j++) begin
      t = {r, l[Q_W-1]};
      l = {l[Q_W-2:0], 1'b0};
      if (t >= {1'b0, n}) begin
        t  = t - {1'b0, n};
        qq = {qq[Q_W-2:0], 1'b1};
      end else begin
        qq = {qq[Q_W-2:0], 1'b0};
      end
      r = t[LEN_W-1:0];
    end
    return {r, l, qq};
  endfunction

  logic             v1_q, v2_q, v3_q, vo_q;
  ls_t              s1_q, s2_q, s3_q;
  logic [Q_W-1:0]   ge1_q;
  logic [LEN_W-1:0] k1_q, k2_q;
  logic [Q_W-1:0]   mag2_q;
  logic [PROD_W-1:0] prod3_q;
  logic [PROD_W-1:0] num_c;
  lerp_t            out_q;

  logic             dv_q  [0:QDIV_STAGES];
  ls_t              ds_q  [0:QDIV_STAGES];
  logic [LEN_W-1:0] rem_q [0:QDIV_STAGES];
  logic [Q_W-1:0]   lo_q  [0:QDIV_STAGES];
  logic [Q_W-1:0]   quo_q [0:QDIV_STAGES];

  logic [Q_W:0]   sum_c;
  logic [Q_W-1:0] m_c, gain_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      dv_q[0]  <= 1'b0;
    end else if (en_i) begin
      v1_q     <= vld_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      dv_q[0]  <= v3_q;
    end
  end

  // L1: edge levels and frame counts
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q.pass   <= data_i.pass;
      s1_q.rd     <= data_i.rd;
      s1_q.zero_d <= data_i.zero_d;
      s1_q.sample <= data_i.sample;
      s1_q.gs     <= data_i.rd ? ONE - data_i.rs : data_i.rs;
      s1_q.up     <= 1'b0;
      s1_q.n      <= {1'b0, data_i.b} - {1'b0, data_i.a} + LEN_W'(1);
      ge1_q       <= data_i.rd ? ONE - data_i.re : data_i.re;
      k1_q        <= {1'b0, data_i.f} - {1'b0, data_i.a} + LEN_W'(1);
    end
  end

  // L2: direction and size of the level step
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q.pass   <= s1_q.pass;
      s2_q.rd     <= s1_q.rd;
      s2_q.zero_d <= s1_q.zero_d;
      s2_q.sample <= s1_q.sample;
      s2_q.gs     <= s1_q.gs;
      s2_q.n      <= s1_q.n;
      s2_q.up     <= (ge1_q >= s1_q.gs);
      mag2_q      <= (ge1_q >= s1_q.gs) ? ge1_q - s1_q.gs : s1_q.gs - ge1_q;
      k2_q        <= k1_q;
    end
  end

  // L3: k * |delta|
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q    <= s2_q;
      prod3_q <= PROD_W'(k2_q) * PROD_W'(mag2_q);
    end
  end

  // L4: add n/2, upper bits start the remainder (below n by construction)
  assign num_c = prod3_q + PROD_W'(s3_q.n >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ds_q[0]  <= s3_q;
      rem_q[0] <= num_c[PROD_W-1:Q_W];
      lo_q[0]  <= num_c[Q_W-1:0];
      quo_q[0] <= '0;
    end
  end

  // divide stages
  for (genvar i = 0; i < QDIV_STAGES; i++) begin : g_div
    logic [PACK_W-1:0] nx;
    assign nx = div_steps(rem_q[i], lo_q[i], quo_q[i], ds_q[i].n);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i+1] <= 1'b0;
      end else if (en_i) begin
        dv_q[i+1] <= dv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ds_q[i+1]  <= ds_q[i];
        rem_q[i+1] <= nx[PACK_W-1:2*Q_W];
        lo_q[i+1]  <= nx[2*Q_W-1:Q_W];
        quo_q[i+1] <= nx[Q_W-1:0];
      end
    end
  end

  // gain, clamped to one; an empty window takes the end level
  always_comb begin
    m_c   = quo_q[QDIV_STAGES];
    sum_c = {1'b0, ds_q[QDIV_STAGES].gs} + {1'b0, m_c};
    if (ds_q[QDIV_STAGES].zero_d) begin
      gain_c = ds_q[QDIV_STAGES].rd ? '0 : ONE;
    end else if (ds_q[QDIV_STAGES].up) begin
      gain_c = (sum_c > {1'b0, ONE}) ? ONE : sum_c[Q_W-1:0];
    end else begin
      gain_c = (m_c > ds_q[QDIV_STAGES].gs) ? '0 : ds_q[QDIV_STAGES].gs - m_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= dv_q[QDIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.pass   <= ds_q[QDIV_STAGES].pass;
      out_q.sample <= ds_q[QDIV_STAGES].sample;
      out_q.gain   <= gain_c;
    end
  end

  assign vld_o  = vo_q;
  assign data_o = out_q;

endmodule

// ===== rtl/tcg_log2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_log2
// log2(1 + gain) in Q1.23 by repeated squaring, one squaring per stage.
// ----------------------------------------------------------------------------
module tcg_log2 (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  tcg_pkg::lerp_t data_i,
  output logic           vld_o,
  output tcg_pkg::log_t  data_o
);
  import tcg_pkg::*;

  logic                       v_q   [0:LOG_STEPS];
  logic                       p_q   [0:LOG_STEPS];
  logic signed [SAMPLE_W-1:0] s_q   [0:LOG_STEPS];
  logic                       sat_q [0:LOG_STEPS];
  logic [Q_W-1:0]             y_q   [0:LOG_STEPS];
  logic [Q_W-1:0]             res_q [0:LOG_STEPS];
  logic                       vo_q;
  log_t                       out_q;

  logic [Q_W:0] rnd_c;

  // stage 0: y = 1 + gain, kept in [1, 2)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0]   <= data_i.pass;
      s_q[0]   <= data_i.sample;
      sat_q[0] <= (data_i.gain >= ONE);
      y_q[0]   <= ONE | data_i.gain;
      res_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < LOG_STEPS; i++) begin : g_sq
    logic [2*Q_W-1:0] sq;
    logic [Q_W:0]     t;
    assign sq = (2*Q_W)'(y_q[i]) * (2*Q_W)'(y_q[i]);
    assign t  = sq[2*Q_W-1:FRAC_W];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    // square, and halve when it reaches two
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[i+1]   <= p_q[i];
        s_q[i+1]   <= s_q[i];
        sat_q[i+1] <= sat_q[i];
        y_q[i+1]   <= t[Q_W] ? t[Q_W:1] : t[Q_W-1:0];
        res_q[i+1] <= {res_q[i][Q_W-2:0], t[Q_W]};
      end
    end
  end

  assign rnd_c = {1'b0, res_q[LOG_STEPS]} + (Q_W+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[LOG_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.pass   <= p_q[LOG_STEPS];
      out_q.sample <= s_q[LOG_STEPS];
      out_q.scale  <= sat_q[LOG_STEPS] ? ONE : rnd_c[Q_W:1];
    end
  end

  assign vld_o  = vo_q;
  assign data_o = out_q;

endmodule

// ===== rtl/timed_crossfade_gain_top.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle unless the output stalls; the 24-stage ratio
// divider and the 24-stage squaring chain of the log2 unit are fully pipelined,
// so nothing iterates in place.
// A stalled output holds every stage; bubbles flow on while the output is empty.
// Reset: asynchronous, active low; clears valid bits and the fade registers to zero.
// ----------------------------------------------------------------------------
// timed_crossfade_gain_top
// Crossfade gain over an absolute time window, applied to one sample per request,
// with an APB-style register port.
// ----------------------------------------------------------------------------
module timed_crossfade_gain_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tcg_pkg::ADDR_W-1:0]          paddr,
  input  logic [tcg_pkg::DATA_W-1:0]          pwdata,
  output logic [tcg_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  // sample in
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [tcg_pkg::TIME_W-1:0]          block_start_i,
  input  logic [tcg_pkg::LEN_W-1:0]           block_length_i,
  input  logic [tcg_pkg::IDX_W-1:0]           frame_index_i,
  input  logic signed [tcg_pkg::SAMPLE_W-1:0] sample_in_i,
  // sample out
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tcg_pkg::SAMPLE_W-1:0] sample_out_o
);
  import tcg_pkg::*;

  localparam logic [2*Q_W-1:0] HALF_LSB = (2*Q_W)'(1) << (FRAC_W - 1);

  logic [TIME_W-1:0] fade_start_q, fade_end_q;
  logic              ramp_down_q;
  reg_idx_e          reg_idx;
  logic              en;

  logic   f_vld, r_vld, l_vld, g_vld;
  front_t f_data;
  ratio_t r_data;
  lerp_t  l_data;
  log_t   g_data;

  logic                       m0_vld_q, m1_vld_q, out_vld_q;
  logic                       m0_pass_q, m1_pass_q, m0_neg_q, m1_neg_q;
  logic signed [SAMPLE_W-1:0] m0_sample_q, m1_sample_q, out_sample_q;
  logic [SAMPLE_W-1:0]        m0_abs_q;
  logic [Q_W-1:0]             m0_scale_q;
  logic [2*Q_W-1:0]           m1_prod_q;

  logic [2*Q_W-1:0]    rsum;
  logic [Q_W:0]        mag, negm;
  logic [SAMPLE_W-1:0] res;

  // register port
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_start_q <= '0;
      fade_end_q   <= '0;
      ramp_down_q  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_FADE_START: fade_start_q <= pwdata;
        REG_FADE_END:   fade_end_q   <= pwdata;
        REG_RAMP_DOWN:  ramp_down_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FADE_START: prdata = fade_start_q;
      REG_FADE_END:   prdata = fade_end_q;
      REG_RAMP_DOWN:  prdata = {{(DATA_W-1){1'b0}}, ramp_down_q};
      default:        prdata = '0;
    endcase
  end

  // whole pipe advances unless a result waits at the output
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  tcg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (in_valid_i),
    .bs_i     (block_start_i),
    .len_i    (block_length_i),
    .f_i      (frame_index_i),
    .sample_i (sample_in_i),
    .st_i     (fade_start_q),
    .fend_i   (fade_end_q),
    .rd_i     (ramp_down_q),
    .vld_o    (f_vld),
    .data_o   (f_data)
  );

  tcg_ratio u_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (f_vld),
    .data_i (f_data),
    .vld_o  (r_vld),
    .data_o (r_data)
  );

  tcg_lerp u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (r_vld),
    .data_i (r_data),
    .vld_o  (l_vld),
    .data_o (l_data)
  );

  tcg_log2 u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (l_vld),
    .data_i (l_data),
    .vld_o  (g_vld),
    .data_o (g_data)
  );

  // scaling stages: magnitude, product, round and saturate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m0_vld_q  <= 1'b0;
      m1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      m0_vld_q  <= g_vld;
      m1_vld_q  <= m0_vld_q;
      out_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m0_pass_q   <= g_data.pass;
      m0_sample_q <= g_data.sample;
      m0_neg_q    <= g_data.sample[SAMPLE_W-1];
      m0_abs_q    <= g_data.sample[SAMPLE_W-1] ? SAMPLE_W'(-g_data.sample)
                                               : SAMPLE_W'(g_data.sample);
      m0_scale_q  <= g_data.scale;
      m1_pass_q   <= m0_pass_q;
      m1_sample_q <= m0_sample_q;
      m1_neg_q    <= m0_neg_q;
      m1_prod_q   <= (2*Q_W)'(m0_abs_q) * (2*Q_W)'(m0_scale_q);
      out_sample_q <= m1_pass_q ? m1_sample_q : res;
    end
  end

  // round halves away from zero, then saturate
  always_comb begin
    rsum = m1_prod_q + HALF_LSB;
    mag  = rsum[2*Q_W-1:FRAC_W];
    negm = -mag;
    if (m1_neg_q) begin
      res = (mag > {1'b0, ONE}) ? ONE : negm[SAMPLE_W-1:0];
    end else begin
      res = (mag > {1'b0, ONE - Q_W'(1)}) ? ONE - Q_W'(1) : mag[SAMPLE_W-1:0];
    end
  end

  assign out_valid_o  = out_vld_q;
  assign sample_out_o = out_sample_q;

`ifndef SYNTH
  // a waiting result freezes the scaling stage behind it
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(m1_vld_q) && $stable(m1_prod_q)))
    else $error("scaling stage moved during an output stall");

  // passing samples leave unchanged
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && m1_vld_q && m1_pass_q) |=> (sample_out_o == $past(m1_sample_q)))
    else $error("passing sample was altered");

  // a zero product gives a zero sample
  a_zero_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && m1_vld_q && !m1_pass_q && (m1_prod_q == '0)) |=> (sample_out_o == '0))
    else $error("zero product gave a nonzero sample");

  // the valid bit at the output follows the scaling stage when the pipe moves
  a_valid_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (out_valid_o == $past(m1_vld_q)))
    else $error("output valid lost or invented");
`endif

endmodule

// ===== tb/timed_crossfade_gain_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_crossfade_gain_top_tb
// Drives sample requests through the crossfade gain pipeline and compares each
// output sample against an in-bench fixed point prediction of the fade ramp.
// ----------------------------------------------------------------------------
module timed_crossfade_gain_top_tb;
  import tcg_pkg::*;

  typedef struct packed {
    logic [TIME_W-1:0]          bstart;
    logic [LEN_W-1:0]           blen;
    logic [IDX_W-1:0]           fidx;
    logic signed [SAMPLE_W-1:0] smp;
  } sample_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [TIME_W-1:0] block_start_i = '0;
  logic [LEN_W-1:0] block_length_i = '0;
  logic [IDX_W-1:0] frame_index_i = '0;
  logic signed [SAMPLE_W-1:0] sample_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out_o;

  timed_crossfade_gain_top DUT (.*);

  always #5 clk_i = ~clk_i;

  // fade registers as the bench sees them
  logic [TIME_W-1:0] win_start = '0, win_end = '0;
  logic              win_down = 1'b0;

  sample_req_t       pending_reqs[$];
  logic [SAMPLE_W-1:0] expected_samples[$];
  int  errors = 0;
  int  hold_off = 0;     // long receiver stall, cycles left
  bit  stall_on = 0;
  bit  send_on = 1;
  int  burst_left = 0, gap_left = 0;

  // rounded window ratio in Q1.23
  function automatic logic [63:0] win_ratio(logic [63:0] num, logic [63:0] den);
    logic [63:0] r, q;
    logic        c;
    if (num >= den) return 64'(ONE);
    r = num; q = 0;
    for (int i = 0; i < 24; i++) begin
      c = r[63];
      r = r << 1;
      q = q << 1;
      if (c || r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  // log2(1+g) by repeated squaring
  function automatic logic [63:0] log_gain(logic [63:0] g);
    logic [63:0] y, res;
    if (g >= 64'(ONE)) return 64'(ONE);
    y = 64'(ONE) + g; res = 0;
    for (int i = 0; i < 24; i++) begin
      y = (y * y) >> 23;
      res = res << 1;
      if (y >= 2 * 64'(ONE)) begin
        y = y >> 1;
        res[0] = 1'b1;
      end
    end
    return (res + 1) >> 1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] faded_sample(sample_req_t q);
    logic [63:0] len, be, ws, we, a, b, d, gs, ge, gain, n, k, m, mag, rs, re;
    logic [63:0] st, en;
    st = win_start; en = win_end;
    len = 64'(q.blen);
    if (len < 1) len = 1;
    if (len > 64'(MAX_BLOCK)) len = 64'(MAX_BLOCK);
    be = (q.bstart > ~64'd0 - (len - 1)) ? ~64'd0 : q.bstart + len - 1;
    if (st > en || st > be || en < q.bstart) return q.smp;
    ws = (st > q.bstart) ? st : q.bstart;
    we = (en < be) ? en : be;
    a = ws - q.bstart;
    b = we - q.bstart;
    if (64'(q.fidx) < a || 64'(q.fidx) > b) return q.smp;
    d = en - st;
    if (d == 0) begin
      gain = win_down ? 0 : 64'(ONE);
    end else begin
      rs = win_ratio(ws - st, d);
      re = win_ratio(we - st, d);
      gs = win_down ? 64'(ONE) - rs : rs;
      ge = win_down ? 64'(ONE) - re : re;
      n = b - a + 1;
      k = 64'(q.fidx) - a + 1;
      if (ge >= gs) begin
        m = (k * (ge - gs) + n / 2) / n;
        gain = gs + m;
      end else begin
        m = (k * (gs - ge) + n / 2) / n;
        gain = (m > gs) ? 0 : gs - m;
      end
      if (gain > 64'(ONE)) gain = 64'(ONE);
    end
    mag = 64'(q.smp < 0 ? -48'(q.smp) : 48'(q.smp)) * log_gain(gain);
    mag = (mag + 64'(ONE >> 1)) >> 23;
    if (q.smp < 0) begin
      if (mag > 64'h800000) mag = 64'h800000;
      return SAMPLE_W'(-mag);
    end
    if (mag > 64'h7FFFFF) mag = 64'h7FFFFF;
    return SAMPLE_W'(mag);
  endfunction

  // request driver: bursts and gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end
        if (gap_left > 0 && burst_left == 0) gap_left <= gap_left - 1;
        if (send_on && pending_reqs.size() > 0 && (burst_left > 0 || gap_left == 0)) begin
          sample_req_t q;
          q = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          block_start_i <= q.bstart;
          block_length_i <= q.blen;
          frame_index_i <= q.fidx;
          sample_in_i <= q.smp;
          if (burst_left > 0) burst_left <= burst_left - 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // prediction at acceptance
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      expected_samples.push_back(faded_sample({block_start_i, block_length_i,
                                               frame_index_i, sample_in_i}));
  end

  // receiver stall pattern and result check
  always @(posedge clk_i) begin
    logic [SAMPLE_W-1:0] exp_s;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $error("sample_out: unexpected result %h", sample_out_o);
          errors++;
        end else begin
          exp_s = expected_samples.pop_front();
          if (sample_out_o !== exp_s) begin
            $error("sample_out: expected %h actual %h", exp_s, sample_out_o);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready_i <= 1'b0;
      end else if (stall_on) begin
        out_ready_i <= ($urandom_range(3, 0) != 0);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic reg_write(input reg_idx_e idx, input logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(8 * idx); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_FADE_START: win_start = val;
      REG_FADE_END:   win_end = val;
      default:        win_down = val[0];
    endcase
  endtask

  task automatic drain;
    while (pending_reqs.size() > 0 || in_valid_i || expected_samples.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic push_req(input logic [63:0] bs, input logic [LEN_W-1:0] l,
                          input logic [IDX_W-1:0] f, input logic [23:0] s);
    pending_reqs.push_back({bs, l, f, s});
  endtask

  // random block that tends to hit the window
  task automatic push_random;
    logic [63:0] bs;
    logic [LEN_W-1:0] l;
    logic [IDX_W-1:0] f;
    int pick;
    pick = $urandom_range(9, 0);
    l = (pick == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(64, 1));
    bs = (pick == 1) ? {$urandom, $urandom}
                     : win_start + 64'($urandom_range(80, 0)) - 64'($urandom_range(80, 0));
    f = (pick == 2) ? IDX_W'($urandom) : IDX_W'($urandom_range(l > 0 ? l - 1 : 0, 0));
    push_req(bs, l, f, 24'($urandom));
  endtask

  task automatic random_phase(input int cnt);
    for (int i = 0; i < cnt; i++) push_random();
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: window 100..163, ramp up
    reg_write(REG_FADE_START, 64'd100);
    reg_write(REG_FADE_END, 64'd163);
    reg_write(REG_RAMP_DOWN, 64'd0);
    push_req(64'd90, 13'd40, 12'd0, 24'h7FFFFF);      // before window
    push_req(64'd90, 13'd40, 12'd10, 24'h800000);     // window start
    push_req(64'd90, 13'd40, 12'd39, 24'h7FFFFF);
    push_req(64'd150, 13'd20, 12'd13, 24'h800000);    // window end
    push_req(64'd150, 13'd20, 12'd14, 24'h123456);    // past window end
    push_req(64'd0, 13'd50, 12'd5, 24'h400000);       // no overlap
    push_req(64'd200, 13'd10, 12'd0, 24'h400000);     // no overlap, later
    push_req(64'd100, 13'd0, 12'd0, 24'hC00000);      // zero length
    push_req(64'd60, 13'd8191, 12'd4095, 24'h000001); // oversize length
    push_req(64'd120, 13'd4, 12'd4095, 24'hFFFFFF);   // frame beyond block
    push_req(64'hFFFF_FFFF_FFFF_FFF0, 13'd4096, 12'd3, 24'h000000);
    drain();
    reg_write(REG_RAMP_DOWN, 64'd1);
    push_req(64'd100, 13'd64, 12'd0, 24'h7FFFFF);
    push_req(64'd100, 13'd64, 12'd63, 24'h800000);
    push_req(64'd100, 13'd64, 12'd32, 24'h555555);
    drain();
    // zero-length window, both directions
    reg_write(REG_FADE_END, 64'd100);
    push_req(64'd100, 13'd1, 12'd0, 24'h7FFFFF);
    push_req(64'd98, 13'd5, 12'd2, 24'h800000);
    drain();
    reg_write(REG_RAMP_DOWN, 64'd0);
    push_req(64'd100, 13'd1, 12'd0, 24'h7FFFFF);
    push_req(64'd98, 13'd5, 12'd2, 24'h800000);
    drain();
    // reversed window
    reg_write(REG_FADE_END, 64'd50);
    push_req(64'd60, 13'd64, 12'd5, 24'h7FFFFF);
    push_req(64'd40, 13'd64, 12'd5, 24'h7FFFFF);
    drain();
    // full range window, extremes
    reg_write(REG_FADE_START, 64'd0);
    reg_write(REG_FADE_END, ~64'd0);
    push_req(~64'd0, 13'd1, 12'd0, 24'h7FFFFF);
    push_req(64'd0, 13'd1, 12'd0, 24'h800000);
    drain();

    // random phases, varied windows, some with stalls
    stall_on = 1;
    reg_write(REG_FADE_START, 64'd1000);
    reg_write(REG_FADE_END, 64'd1100);
    random_phase(250);
    // long hold-off while sender keeps offering
    hold_off = 400;
    for (int i = 0; i < 150; i++) push_random();
    repeat (420) @(posedge clk_i);
    // sender pauses until every result has arrived
    send_on = 1'b0;
    while (in_valid_i || expected_samples.size() > 0) @(posedge clk_i);
    send_on = 1'b1;
    drain();
    reg_write(REG_RAMP_DOWN, 64'd1);
    reg_write(REG_FADE_START, 64'hFFFF_FFFF_FFFF_FF00);
    reg_write(REG_FADE_END, ~64'd0);
    random_phase(200);
    stall_on = 0;
    reg_write(REG_FADE_START, {$urandom, $urandom});
    reg_write(REG_FADE_END, win_start + 64'($urandom_range(3000, 1)));
    random_phase(200);
    stall_on = 1;
    reg_write(REG_RAMP_DOWN, 64'd0);
    reg_write(REG_FADE_START, 64'd5);
    reg_write(REG_FADE_END, 64'd7);
    random_phase(200);
    reg_write(REG_FADE_START, 64'd0);
    reg_write(REG_FADE_END, 64'd0);
    random_phase(100);

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
